// File: rtl/pss_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pss_pkg: shared types, constants and microcode for the plant splitting step
// Holds the request/response payload structs, the configuration record, the
// control word layout and the read-only microprogram of the sequencer.
// ----------------------------------------------------------------------------
package pss_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int PC_W          = 4;
    localparam int CFG_IDX_W     = 3;

    localparam logic CMD_ADVANCE = 1'b0;
    localparam logic CMD_LOAD    = 1'b1;

    localparam logic MODE_MOTOR  = 1'b0;
    localparam logic MODE_MASS   = 1'b1;

    localparam logic [PC_W-1:0] LOAD_STEP = 4'd15;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PLANT_MODE = 3'd0,
        CFG_GAIN_Q     = 3'd1,
        CFG_GAIN_P     = 3'd2,
        CFG_DISS_Q     = 3'd3,
        CFG_DISS_P     = 3'd4,
        CFG_STEP_SIZE  = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic                     cmd;
        logic signed [DATA_W-1:0] drive_a;
        logic signed [DATA_W-1:0] drive_b;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos_out;
        logic signed [DATA_W-1:0] mom_out;
        logic signed [DATA_W-1:0] port_y_a;
        logic signed [DATA_W-1:0] port_y_b;
        logic                     overflow;
    } rsp_t;

    typedef struct packed {
        logic        plant_mode;
        logic [30:0] gain_q;
        logic [30:0] gain_p;
        logic [30:0] diss_q;
        logic [30:0] diss_p;
        logic [16:0] step_size;
    } cfg_t;

    // multiplier operand A: always a non-negative coefficient
    typedef enum logic [2:0] {
        OPA_GAIN_Q,
        OPA_GAIN_P,
        OPA_DISS_Q,
        OPA_DISS_P,
        OPA_DT
    } opa_t;

    // multiplier operand B: a working register
    typedef enum logic [2:0] {
        OPB_Q,
        OPB_P,
        OPB_GQ,
        OPB_GP,
        OPB_FQ,
        OPB_FP
    } opb_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_GQ,
        DST_GP,
        DST_FQ,
        DST_FP,
        DST_Q,
        DST_P,
        DST_LOAD
    } dst_t;

    typedef enum logic [2:0] {
        BASE_ZERO,
        BASE_Q,
        BASE_P,
        BASE_UA,
        BASE_UB
    } base_t;

    typedef enum logic {
        JMP_NONE,
        JMP_LOAD
    } jmp_t;

    // One control word: issue a product now, retire the previous product
    // into dst as (base +/- rounded product), or load q and p from the drives.
    typedef struct packed {
        opa_t            opa;
        opb_t            opb;
        logic            half;
        dst_t            dst;
        base_t           base;
        logic            sub;
        logic            mass_zero;
        jmp_t            jmp;
        logic [PC_W-1:0] target;
        logic            last;
    } uword_t;

    typedef struct packed {
        logic   start;
        logic   run;
        uword_t uw;
    } ctl_t;

    typedef struct packed {
        logic                     fin;
        logic                     load;
    } seq_stat_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] q;
        logic signed [DATA_W-1:0] p;
        logic signed [DATA_W-1:0] gq;
        logic signed [DATA_W-1:0] gp;
        logic                     ov;
    } dp_stat_t;

    function automatic uword_t mk_uw(opa_t opa, opb_t opb, logic half, dst_t dst,
                                     base_t base, logic sub, logic mass_zero,
                                     logic last);
        uword_t w;
        w.opa       = opa;
        w.opb       = opb;
        w.half      = half;
        w.dst       = dst;
        w.base      = base;
        w.sub       = sub;
        w.mass_zero = mass_zero;
        w.jmp       = JMP_NONE;
        w.target    = '0;
        w.last      = last;
        return w;
    endfunction

    // Microprogram: half step, full step with dissipation and drive, half step, and the load step.
    function automatic uword_t ucode(logic [PC_W-1:0] pc);
        uword_t w;
        case (pc)
            4'd0:
            begin
                w        = mk_uw(OPA_GAIN_Q, OPB_Q, 1'b0, DST_NONE, BASE_ZERO,
                                 1'b0, 1'b0, 1'b0);
                w.jmp    = JMP_LOAD;
                w.target = LOAD_STEP;
            end
            4'd1:  w = mk_uw(OPA_GAIN_P, OPB_P,  1'b0, DST_GQ, BASE_ZERO, 1'b0, 1'b0, 1'b0);
            4'd2:  w = mk_uw(OPA_DT,     OPB_GQ, 1'b1, DST_GP, BASE_ZERO, 1'b0, 1'b0, 1'b0);
            4'd3:  w = mk_uw(OPA_DT,     OPB_GP, 1'b1, DST_P,  BASE_P,    1'b1, 1'b0, 1'b0);
            4'd4:  w = mk_uw(OPA_GAIN_P, OPB_P,  1'b0, DST_Q,  BASE_Q,    1'b0, 1'b0, 1'b0);
            4'd5:  w = mk_uw(OPA_GAIN_Q, OPB_Q,  1'b0, DST_GP, BASE_ZERO, 1'b0, 1'b0, 1'b0);
            4'd6:  w = mk_uw(OPA_DISS_P, OPB_GP, 1'b0, DST_GQ, BASE_ZERO, 1'b0, 1'b0, 1'b0);
            4'd7:  w = mk_uw(OPA_DISS_Q, OPB_GQ, 1'b0, DST_FP, BASE_UB,   1'b1, 1'b0, 1'b0);
            4'd8:  w = mk_uw(OPA_DT,     OPB_FP, 1'b0, DST_FQ, BASE_UA,   1'b1, 1'b1, 1'b0);
            4'd9:  w = mk_uw(OPA_DT,     OPB_FQ, 1'b0, DST_P,  BASE_P,    1'b0, 1'b0, 1'b0);
            4'd10: w = mk_uw(OPA_GAIN_P, OPB_P,  1'b0, DST_Q,  BASE_Q,    1'b0, 1'b0, 1'b0);
            4'd11: w = mk_uw(OPA_GAIN_Q, OPB_Q,  1'b0, DST_GP, BASE_ZERO, 1'b0, 1'b0, 1'b0);
            4'd12: w = mk_uw(OPA_DT,     OPB_GP, 1'b1, DST_GQ, BASE_ZERO, 1'b0, 1'b0, 1'b0);
            4'd13: w = mk_uw(OPA_DT,     OPB_GQ, 1'b1, DST_Q,  BASE_Q,    1'b0, 1'b0, 1'b0);
            4'd14: w = mk_uw(OPA_DT,     OPB_Q,  1'b0, DST_P,  BASE_P,    1'b1, 1'b0, 1'b1);
            4'd15: w = mk_uw(OPA_DT,     OPB_Q,  1'b0, DST_LOAD, BASE_ZERO, 1'b0, 1'b0, 1'b1);
            default: w = mk_uw(OPA_DT,   OPB_Q,  1'b0, DST_NONE, BASE_ZERO, 1'b0, 1'b0, 1'b1);
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

// File: rtl/plant_splitting_step.sv
`default_nettype none
// ----------------------------------------------------------------------------
// plant_splitting_step: one-degree-of-freedom port-Hamiltonian plant emulator
//
// Requests arrive on req_valid/req_ready with req_data (cmd, drive_a,
// drive_b); results leave on rsp_valid/rsp_ready with rsp_data. An advance
// request runs a half step, a full step with dissipation and drive, and a
// second half step on the held state (q, p); a load request presets it.
// The block takes one request at a time. The microprogram has one control
// word per cycle; an advance request sends 14 products through the single
// 32x32 multiplier, one per word, and a final word retires the last product;
// a load request jumps to the load word. The result then moves into the
// output register and the sequencer returns to idle before the next request
// is taken.
// The result is registered, so a new request is accepted while the previous
// result still waits on a stalled receiver; the sequencer holds its finished
// result until the output register is free.
// Configuration writes on cfg_valid/cfg_index/cfg_data are always accepted
// and must only be issued while the block is idle. Reset clears q and p,
// loads the default gains and step size and empties the output register.
// ----------------------------------------------------------------------------
module plant_splitting_step #(
    parameter int FRAC_BITS = pss_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               req_valid,
    output logic                                    req_ready,
    input  wire pss_pkg::req_t                      req_data,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_ready,
    output pss_pkg::rsp_t                           rsp_data,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [pss_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [31:0]                        cfg_data
);

    pss_pkg::cfg_t      cfg_reg;
    pss_pkg::ctl_t      ctl;
    pss_pkg::seq_stat_t st;
    pss_pkg::dp_stat_t  stat;
    pss_pkg::rsp_t      rsp_reg;
    pss_pkg::rsp_t      rsp_next;
    logic               rsp_valid_reg;
    logic               slot_free;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.plant_mode <= pss_pkg::MODE_MOTOR;
            cfg_reg.gain_q     <= 31'd65536;
            cfg_reg.gain_p     <= 31'd65536;
            cfg_reg.diss_q     <= 31'd0;
            cfg_reg.diss_p     <= 31'd0;
            cfg_reg.step_size  <= 17'd655;
        end
        else if (cfg_valid)
        begin
            case (pss_pkg::cfg_idx_t'(cfg_index))
                pss_pkg::CFG_PLANT_MODE: cfg_reg.plant_mode <= cfg_data[0];
                pss_pkg::CFG_GAIN_Q:     cfg_reg.gain_q     <= cfg_data[30:0];
                pss_pkg::CFG_GAIN_P:     cfg_reg.gain_p     <= cfg_data[30:0];
                pss_pkg::CFG_DISS_Q:     cfg_reg.diss_q     <= cfg_data[30:0];
                pss_pkg::CFG_DISS_P:     cfg_reg.diss_p     <= cfg_data[30:0];
                pss_pkg::CFG_STEP_SIZE:  cfg_reg.step_size  <= cfg_data[16:0];
                default: ;
            endcase
        end
    end

    assign slot_free = !rsp_valid_reg || rsp_ready;

    pss_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req_data.cmd),
        .slot_free (slot_free),
        .req_ready (req_ready),
        .ctl       (ctl),
        .st        (st)
    );

    pss_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .cfg     (cfg_reg),
        .drive_a (req_data.drive_a),
        .drive_b (req_data.drive_b),
        .stat    (stat)
    );

    // port outputs: motor reports both gradients, mass only the p gradient, a load zeros
    always_comb
    begin
        rsp_next.pos_out  = stat.q;
        rsp_next.mom_out  = stat.p;
        rsp_next.overflow = stat.ov;
        if (st.load)
        begin
            rsp_next.port_y_a = '0;
            rsp_next.port_y_b = '0;
        end
        else if (cfg_reg.plant_mode == pss_pkg::MODE_MASS)
        begin
            rsp_next.port_y_a = stat.gp;
            rsp_next.port_y_b = '0;
        end
        else
        begin
            rsp_next.port_y_a = stat.gq;
            rsp_next.port_y_b = stat.gp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (st.fin)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st.fin)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

endmodule
`default_nettype wire

// File: rtl/pss_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pss_sequencer: step counter and microcode fetch
// Takes a request when idle, walks the microprogram one word per cycle,
// jumps to the load step for load requests, then waits for the output slot.
// ----------------------------------------------------------------------------
module pss_sequencer (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                req_valid,
    input  wire logic                req_cmd,
    input  wire logic                slot_free,
    output logic                     req_ready,
    output pss_pkg::ctl_t            ctl,
    output pss_pkg::seq_stat_t       st
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    state_t                      state_reg;
    logic [pss_pkg::PC_W-1:0]    pc_reg;
    logic [pss_pkg::PC_W-1:0]    pc_next;
    logic                        load_reg;
    logic                        req_fire;
    pss_pkg::uword_t             uw;

    assign uw        = pss_pkg::ucode(pc_reg);
    assign req_ready = (state_reg == S_IDLE);
    assign req_fire  = req_valid && req_ready;

    always_comb
    begin
        if ((uw.jmp == pss_pkg::JMP_LOAD) && load_reg)
        begin
            pc_next = uw.target;
        end
        else
        begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_comb
    begin
        ctl.start = req_fire;
        ctl.run   = (state_reg == S_RUN);
        ctl.uw    = uw;
        st.fin    = (state_reg == S_DONE) && slot_free;
        st.load   = load_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            load_reg  <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req_valid)
                    begin
                        state_reg <= S_RUN;
                        pc_reg    <= '0;
                        load_reg  <= (req_cmd == pss_pkg::CMD_LOAD);
                    end
                end
                S_RUN:
                begin
                    if (uw.last)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        pc_reg <= pc_next;
                    end
                end
                S_DONE:
                begin
                    // hold until the output register can take the result
                    if (slot_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_start_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire |=> (state_reg == S_RUN) && (pc_reg == '0))
        else $error("request did not start the program at step zero");

    a_load_jump: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) && (pc_reg == '0) && load_reg
        |=> (state_reg == S_RUN) && (pc_reg == pss_pkg::LOAD_STEP))
        else $error("load request did not jump to the load step");

    a_last_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) && uw.last |=> (state_reg == S_DONE))
        else $error("last step did not end the program");

    a_hold_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) && !slot_free |=> (state_reg == S_DONE))
        else $error("result dropped while output slot was busy");

endmodule
`default_nettype wire

// File: rtl/pss_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pss_datapath: shared multiplier, rounding, saturating adder, registers
// Each step issues one 32x32 product and retires the previous one: round
// by FRAC_BITS (or one more for half steps), saturate, add to a base, saturate.
// ----------------------------------------------------------------------------
module pss_datapath #(
    parameter int FRAC_BITS = pss_pkg::FRAC_BITS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire pss_pkg::ctl_t          ctl,
    input  wire pss_pkg::cfg_t          cfg,
    input  wire logic signed [31:0]     drive_a,
    input  wire logic signed [31:0]     drive_b,
    output pss_pkg::dp_stat_t           stat
);

    localparam logic signed [64:0] HALF_F = 65'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [64:0] HALF_H = 65'sd1 <<< FRAC_BITS;
    localparam logic signed [64:0] MAX32  = 65'sd2147483647;
    localparam logic signed [64:0] MIN32  = -65'sd2147483648;

    logic signed [31:0] q_reg, q_next;
    logic signed [31:0] p_reg, p_next;
    logic signed [31:0] gq_reg, gq_next;
    logic signed [31:0] gp_reg, gp_next;
    logic signed [31:0] fq_reg, fq_next;
    logic signed [31:0] fp_reg, fp_next;
    logic signed [31:0] ua_reg;
    logic signed [31:0] ub_reg;
    logic signed [63:0] prod_reg;
    logic               half_reg;
    logic               ov_reg, ov_next;

    logic signed [31:0] opa;
    logic signed [31:0] opb;
    logic signed [63:0] prod_next;
    logic signed [64:0] prod_x;
    logic signed [64:0] rnd_f;
    logic signed [64:0] rnd_h;
    logic signed [64:0] rnd;
    logic               m_ovf;
    logic signed [31:0] m;
    logic signed [31:0] base;
    logic signed [33:0] sum;
    logic               add_ovf;
    logic signed [31:0] res;
    logic               zero_it;
    logic signed [31:0] wb_val;
    logic               ov_hit;

    // operand select and product
    always_comb
    begin
        case (ctl.uw.opa)
            pss_pkg::OPA_GAIN_Q: opa = {1'b0, cfg.gain_q};
            pss_pkg::OPA_GAIN_P: opa = {1'b0, cfg.gain_p};
            pss_pkg::OPA_DISS_Q: opa = {1'b0, cfg.diss_q};
            pss_pkg::OPA_DISS_P: opa = {1'b0, cfg.diss_p};
            pss_pkg::OPA_DT:     opa = {15'd0, cfg.step_size};
            default:             opa = '0;
        endcase
        case (ctl.uw.opb)
            pss_pkg::OPB_Q:  opb = q_reg;
            pss_pkg::OPB_P:  opb = p_reg;
            pss_pkg::OPB_GQ: opb = gq_reg;
            pss_pkg::OPB_GP: opb = gp_reg;
            pss_pkg::OPB_FQ: opb = fq_reg;
            pss_pkg::OPB_FP: opb = fp_reg;
            default:         opb = '0;
        endcase
    end

    assign prod_next = opa * opb;

    // round half up, floor, saturate the retiring product
    always_comb
    begin
        prod_x = {prod_reg[63], prod_reg};
        rnd_f  = (prod_x + HALF_F) >>> FRAC_BITS;
        rnd_h  = (prod_x + HALF_H) >>> (FRAC_BITS + 1);
        rnd    = half_reg ? rnd_h : rnd_f;
        m_ovf  = (rnd > MAX32) || (rnd < MIN32);
        if (rnd > MAX32)
        begin
            m = 32'sh7FFFFFFF;
        end
        else if (rnd < MIN32)
        begin
            m = 32'sh80000000;
        end
        else
        begin
            m = rnd[31:0];
        end
    end

    // base plus or minus product, saturated
    always_comb
    begin
        case (ctl.uw.base)
            pss_pkg::BASE_ZERO: base = '0;
            pss_pkg::BASE_Q:    base = q_reg;
            pss_pkg::BASE_P:    base = p_reg;
            pss_pkg::BASE_UA:   base = ua_reg;
            pss_pkg::BASE_UB:   base = ub_reg;
            default:            base = '0;
        endcase
        if (ctl.uw.sub)
        begin
            sum = {{2{base[31]}}, base} - {{2{m[31]}}, m};
        end
        else
        begin
            sum = {{2{base[31]}}, base} + {{2{m[31]}}, m};
        end
        add_ovf = !((sum[33:31] == 3'b000) || (sum[33:31] == 3'b111));
        if (!add_ovf)
        begin
            res = sum[31:0];
        end
        else if (sum[33])
        begin
            res = 32'sh80000000;
        end
        else
        begin
            res = 32'sh7FFFFFFF;
        end
        // the mass has no drive or dissipation on the q channel
        zero_it = ctl.uw.mass_zero && (cfg.plant_mode == pss_pkg::MODE_MASS);
        wb_val  = zero_it ? 32'sd0 : res;
        ov_hit  = !zero_it && (m_ovf || add_ovf);
    end

    always_comb
    begin
        q_next  = q_reg;
        p_next  = p_reg;
        gq_next = gq_reg;
        gp_next = gp_reg;
        fq_next = fq_reg;
        fp_next = fp_reg;
        ov_next = ov_reg;
        if (ctl.start)
        begin
            ov_next = 1'b0;
        end
        else if (ctl.run)
        begin
            case (ctl.uw.dst)
                pss_pkg::DST_NONE: ;
                pss_pkg::DST_GQ:   gq_next = wb_val;
                pss_pkg::DST_GP:   gp_next = wb_val;
                pss_pkg::DST_FQ:   fq_next = wb_val;
                pss_pkg::DST_FP:   fp_next = wb_val;
                pss_pkg::DST_Q:    q_next  = wb_val;
                pss_pkg::DST_P:    p_next  = wb_val;
                pss_pkg::DST_LOAD:
                begin
                    q_next = ua_reg;
                    p_next = ub_reg;
                end
                default: ;
            endcase
            if ((ctl.uw.dst != pss_pkg::DST_NONE) && (ctl.uw.dst != pss_pkg::DST_LOAD))
            begin
                ov_next = ov_reg || ov_hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg  <= '0;
            p_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            q_reg  <= q_next;
            p_reg  <= p_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gq_reg <= gq_next;
        gp_reg <= gp_next;
        fq_reg <= fq_next;
        fp_reg <= fp_next;
        if (ctl.start)
        begin
            ua_reg <= drive_a;
            ub_reg <= drive_b;
        end
        if (ctl.run)
        begin
            prod_reg <= prod_next;
            half_reg <= ctl.uw.half;
        end
    end

    always_comb
    begin
        stat.q  = q_reg;
        stat.p  = p_reg;
        stat.gq = gq_reg;
        stat.gp = gp_reg;
        stat.ov = ov_reg;
    end

endmodule
`default_nettype wire

// File: dv/tb_plant_splitting_step.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_plant_splitting_step: self-checking bench for the plant splitting step
// Sends load and advance requests, predicts each tick (state, port outputs,
// overflow) with a fixed point Strang step of its own and checks every
// response in order. Both channels idle at random. The receiver also stalls
// for a long stretch, and the run moves through several plant settings.
// ----------------------------------------------------------------------------
module tb_plant_splitting_step;

    localparam int     FRAC          = pss_pkg::FRAC_BITS_DEF;
    localparam longint SAT_HI        = 64'sd2147483647;
    localparam longint SAT_LO        = -64'sd2147483648;
    localparam logic [31:0] Q_MAX    = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN    = 32'h8000_0000;
    localparam logic [30:0] COEF_MAX = '1;
    localparam logic [30:0] ONE      = 31'd65536;
    localparam logic [16:0] DT_MAX   = 17'd65536;
    localparam longint RESET_GAIN    = 65536;
    localparam longint RESET_DT      = 655;
    localparam logic [pss_pkg::CFG_IDX_W-1:0] CFG_SPARE = pss_pkg::CFG_STEP_SIZE + 3'd1;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     DRAIN_CYCLES  = 34;
    localparam int     RANDOM_PHASES = 8;
    localparam int     PHASE_ITEMS   = 200;
    localparam int     TIMEOUT_NS    = 4_000_000;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          req_valid = 1'b0;
    logic                          req_ready;
    pss_pkg::req_t                 req_data  = '0;
    logic                          rsp_valid;
    logic                          rsp_ready = 1'b0;
    pss_pkg::rsp_t                 rsp_data;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [pss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]                   cfg_data  = '0;

    // settings and state the block should hold
    logic   cur_mode;
    longint cur_gain_q;
    longint cur_gain_p;
    longint cur_diss_q;
    longint cur_diss_p;
    longint cur_dt;
    longint plant_q;
    longint plant_p;

    pss_pkg::rsp_t predicted_ticks[$];
    pss_pkg::rsp_t tick_due;
    int            fail_count = 0;
    logic          calm       = 1'b0;
    int unsigned   hold_id    = 0;
    int unsigned   hold_ack   = 0;
    int unsigned   hold_left  = 0;

    plant_splitting_step dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp32(input longint v, inout bit ov);
        if (v > SAT_HI)
        begin
            ov = 1'b1;
            return SAT_HI;
        end
        if (v < SAT_LO)
        begin
            ov = 1'b1;
            return SAT_LO;
        end
        return v;
    endfunction

    // exact product, add half an LSB, floor-shift by sh, saturate
    function automatic longint fx_mul(input longint a, input longint b, input int sh,
                                      inout bit ov);
        longint prod;
        prod = a * b + (longint'(1) <<< (sh - 1));
        return clamp32(prod >>> sh, ov);
    endfunction

    function automatic pss_pkg::rsp_t strang_tick(input pss_pkg::req_t r);
        pss_pkg::rsp_t res;
        bit            ov;
        longint        ua, ub, q, p, gq, gp, fq, fp;
        ov  = 1'b0;
        res = '0;
        ua  = $signed(r.drive_a);
        ub  = $signed(r.drive_b);
        if (r.cmd == pss_pkg::CMD_LOAD)
        begin
            plant_q = ua;
            plant_p = ub;
        end
        else
        begin
            // conservative half step at the old gradient
            gq = fx_mul(cur_gain_q, plant_q, FRAC, ov);
            gp = fx_mul(cur_gain_p, plant_p, FRAC, ov);
            q  = clamp32(plant_q + fx_mul(cur_dt, gp, FRAC + 1, ov), ov);
            p  = clamp32(plant_p - fx_mul(cur_dt, gq, FRAC + 1, ov), ov);
            // full step with dissipation and drive
            gq = fx_mul(cur_gain_q, q, FRAC, ov);
            gp = fx_mul(cur_gain_p, p, FRAC, ov);
            fq = 0;
            if (cur_mode == pss_pkg::MODE_MOTOR)
                fq = clamp32(ua - fx_mul(cur_diss_q, gq, FRAC, ov), ov);
            fp = clamp32(ub - fx_mul(cur_diss_p, gp, FRAC, ov), ov);
            q  = clamp32(q + fx_mul(cur_dt, fq, FRAC, ov), ov);
            p  = clamp32(p + fx_mul(cur_dt, fp, FRAC, ov), ov);
            // second half step; ports read this gradient
            gq = fx_mul(cur_gain_q, q, FRAC, ov);
            gp = fx_mul(cur_gain_p, p, FRAC, ov);
            plant_q = clamp32(q + fx_mul(cur_dt, gp, FRAC + 1, ov), ov);
            plant_p = clamp32(p - fx_mul(cur_dt, gq, FRAC + 1, ov), ov);
            if (cur_mode == pss_pkg::MODE_MOTOR)
            begin
                res.port_y_a = 32'(gq);
                res.port_y_b = 32'(gp);
            end
            else
                res.port_y_a = 32'(gp);
            res.overflow = ov;
        end
        res.pos_out = 32'(plant_q);
        res.mom_out = 32'(plant_p);
        return res;
    endfunction

    // Leaves valid high after acceptance; the next call or settle() decides.
    task automatic send_tick(input logic cmd, input logic [31:0] a, input logic [31:0] b);
        pss_pkg::req_t r;
        r.cmd     = cmd;
        r.drive_a = a;
        r.drive_b = b;
        if (!calm && $urandom_range(0, 99) < 33)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predicted_ticks.push_back(strang_tick(r));
    endtask

    task automatic settle();
        req_valid <= 1'b0;
        while (predicted_ticks.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [pss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            pss_pkg::CFG_PLANT_MODE: cur_mode   = data[0];
            pss_pkg::CFG_GAIN_Q:     cur_gain_q = data[30:0];
            pss_pkg::CFG_GAIN_P:     cur_gain_p = data[30:0];
            pss_pkg::CFG_DISS_Q:     cur_diss_q = data[30:0];
            pss_pkg::CFG_DISS_P:     cur_diss_p = data[30:0];
            pss_pkg::CFG_STEP_SIZE:  cur_dt     = data[16:0];
            default:                 ;
        endcase
    endtask

    // Write every register with junk above its width, plus one spare index.
    task automatic set_plant(input logic mode, input logic [30:0] gq, gp, dq, dp,
                             input logic [16:0] dt);
        settle();
        write_reg(pss_pkg::CFG_PLANT_MODE, {31'($urandom), mode});
        write_reg(pss_pkg::CFG_GAIN_Q, {1'($urandom), gq});
        write_reg(pss_pkg::CFG_GAIN_P, {1'($urandom), gp});
        write_reg(pss_pkg::CFG_DISS_Q, {1'($urandom), dq});
        write_reg(pss_pkg::CFG_DISS_P, {1'($urandom), dp});
        write_reg(pss_pkg::CFG_STEP_SIZE, {15'($urandom), dt});
        write_reg(CFG_SPARE + 3'($urandom_range(0, 1)), $urandom);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] draw_drive();
        case ($urandom_range(0, 19))
            0:             return Q_MAX;
            1:             return Q_MIN;
            2:             return '0;
            3, 4, 5, 6, 7: return $urandom;
            default:       return 32'($urandom_range(0, 32'h1F_FFFF)) - 32'h0010_0000;
        endcase
    endfunction

    function automatic logic [30:0] draw_coeff(input int unsigned span);
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return COEF_MAX;
            2, 3:    return 31'($urandom);
            default: return 31'($urandom_range(0, span));
        endcase
    endfunction

    function automatic logic [16:0] draw_dt();
        case ($urandom_range(0, 19))
            0:          return '0;
            1:          return DT_MAX;
            2, 3, 4, 5: return 17'($urandom_range(0, 65536));
            default:    return 17'($urandom_range(0, 6554));
        endcase
    endfunction

    task automatic pick_settings();
        set_plant(1'($urandom), draw_coeff(4 * 65536), draw_coeff(4 * 65536),
                  draw_coeff(2 * 65536), draw_coeff(2 * 65536), draw_dt());
    endtask

    // Load a state, then run a burst of advances with a stray load now and then.
    task automatic run_random(input int n);
        int left;
        int burst;
        left = n;
        while (left > 0)
        begin
            send_tick(pss_pkg::CMD_LOAD, draw_drive(), draw_drive());
            left--;
            burst = $urandom_range(3, 30);
            while (burst > 0 && left > 0)
            begin
                send_tick(($urandom_range(0, 24) == 0) ? pss_pkg::CMD_LOAD
                                                       : pss_pkg::CMD_ADVANCE,
                          draw_drive(), draw_drive());
                burst--;
                left--;
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_tick(pss_pkg::CMD_ADVANCE, '0, '0);
        send_tick(pss_pkg::CMD_ADVANCE, Q_MAX, Q_MIN);
        send_tick(pss_pkg::CMD_LOAD, Q_MAX, Q_MIN);
        send_tick(pss_pkg::CMD_ADVANCE, '0, '0);
        send_tick(pss_pkg::CMD_LOAD, Q_MIN, Q_MAX);
        send_tick(pss_pkg::CMD_ADVANCE, Q_MIN, Q_MAX);
        send_tick(pss_pkg::CMD_LOAD, 32'hFFFF_FFFF, 32'd1);
        send_tick(pss_pkg::CMD_ADVANCE, 32'h0001_0000, 32'hFFFF_0000);
    endtask

    task automatic test_extreme_settings();
        set_plant(pss_pkg::MODE_MOTOR, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, DT_MAX);
        send_tick(pss_pkg::CMD_LOAD, Q_MAX, Q_MAX);
        send_tick(pss_pkg::CMD_ADVANCE, Q_MIN, Q_MAX);
        send_tick(pss_pkg::CMD_LOAD, Q_MIN, Q_MIN);
        send_tick(pss_pkg::CMD_ADVANCE, Q_MAX, Q_MIN);
        send_tick(pss_pkg::CMD_ADVANCE, '0, '0);
        // mass: drive_a must have no effect, port_y_b stays zero
        set_plant(pss_pkg::MODE_MASS, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, DT_MAX);
        send_tick(pss_pkg::CMD_LOAD, Q_MAX, Q_MIN);
        send_tick(pss_pkg::CMD_ADVANCE, Q_MAX, Q_MAX);
        send_tick(pss_pkg::CMD_ADVANCE, Q_MIN, Q_MIN);
    endtask

    task automatic test_zero_settings();
        set_plant(pss_pkg::MODE_MOTOR, '0, '0, '0, '0, '0);
        send_tick(pss_pkg::CMD_LOAD, 32'h0003_0000, 32'hFFFD_0000);
        send_tick(pss_pkg::CMD_ADVANCE, Q_MAX, Q_MIN);
        // mass ignores the q resistance
        set_plant(pss_pkg::MODE_MASS, ONE, ONE, COEF_MAX, '0, 17'd6554);
        send_tick(pss_pkg::CMD_LOAD, 32'h0001_0000, 32'h0001_0000);
        send_tick(pss_pkg::CMD_ADVANCE, Q_MAX, '0);
        send_tick(pss_pkg::CMD_ADVANCE, Q_MIN, 32'h0001_0000);
    endtask

    task automatic test_random_settings();
        int k;
        for (k = 0; k < RANDOM_PHASES; k++)
        begin
            pick_settings();
            calm <= (k == 2);
            run_random(PHASE_ITEMS);
        end
    endtask

    task automatic test_output_stall();
        pick_settings();
        hold_id <= hold_id + 1;
        run_random(PHASE_ITEMS);
    endtask

    always @(posedge clk)
    begin
        if (hold_id != hold_ack)
        begin
            hold_ack  <= hold_id;
            hold_left <= HOLD_CYCLES;
            rsp_ready <= 1'b0;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= calm || ($urandom_range(0, 99) >= 33);
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (predicted_ticks.size() == 0)
            begin
                if (fail_count < 10)
                    $display("%0t: response with no request pending: %h", $time, rsp_data);
                fail_count++;
            end
            else
            begin
                tick_due = predicted_ticks.pop_front();
                if (tick_due.pos_out !== rsp_data.pos_out
                    || tick_due.mom_out !== rsp_data.mom_out
                    || tick_due.port_y_a !== rsp_data.port_y_a
                    || tick_due.port_y_b !== rsp_data.port_y_b
                    || tick_due.overflow !== rsp_data.overflow)
                begin
                    if (fail_count < 10)
                        $display("%0t: tick mismatch q/p/ya/yb/ov exp %h %h %h %h %b got %h %h %h %h %b",
                                 $time, tick_due.pos_out, tick_due.mom_out,
                                 tick_due.port_y_a, tick_due.port_y_b, tick_due.overflow,
                                 rsp_data.pos_out, rsp_data.mom_out,
                                 rsp_data.port_y_a, rsp_data.port_y_b, rsp_data.overflow);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        cur_mode   = pss_pkg::MODE_MOTOR;
        cur_gain_q = RESET_GAIN;
        cur_gain_p = RESET_GAIN;
        cur_diss_q = 0;
        cur_diss_p = 0;
        cur_dt     = RESET_DT;
        plant_q    = 0;
        plant_p    = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_extreme_settings();
        test_zero_settings();
        test_random_settings();
        test_output_stall();
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_plant_splitting_step: PASS");
        else
            $display("tb_plant_splitting_step: FAIL");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_plant_splitting_step: FAIL");
        $finish;
    end

endmodule
